// ----- rtl/n2w_pkg.sv -----
// Shared types, word codes and constants for the number-to-words reader.
// No dependencies; every other file imports this package.
package n2w_pkg;

  localparam int unsigned AmountW  = 32;
  localparam int unsigned WordW    = 5;
  localparam int unsigned DigitCnt = 10;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned BcdW     = DigitCnt * DigitW;
  localparam int unsigned ConvCntW = $clog2(DigitCnt);
  localparam int unsigned GroupW   = 2;
  localparam int unsigned RemW     = 34;

  localparam longint unsigned Giga = 64'd1000000000;

  localparam logic [WordW-1:0] W_ZERO     = 5'd0;
  localparam logic [WordW-1:0] W_TEN      = 5'd10;
  localparam logic [WordW-1:0] W_TENS_OFF = 5'd18;
  localparam logic [WordW-1:0] W_HUNDRED  = 5'd28;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    SLOT_HDIG,
    SLOT_HUND,
    SLOT_TENS,
    SLOT_ONES,
    SLOT_MAG
  } slot_e;

  typedef struct packed {
    logic              load;
    logic              convert;
    logic              probe;
    logic              flush;
    logic [GroupW-1:0] group;
    slot_e             slot;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // THOUSAND, MILLION and BILLION follow HUNDRED in code order
  function automatic logic [WordW-1:0] mag_word(input logic [GroupW-1:0] group);
    mag_word = W_HUNDRED + WordW'(group);
  endfunction

endpackage

// ----- rtl/n2w_if.sv -----
// Valid/ready channel interfaces for the amount input and the word output.
// Depends on n2w_pkg for field widths.
interface n2w_in_if import n2w_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [AmountW-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink (input valid, input amount, output ready);
endinterface

interface n2w_out_if import n2w_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] word;
  logic             last;

  modport source (output valid, output word, output last, input ready);
  modport sink (input valid, input word, input last, output ready);
endinterface

// ----- rtl/number_to_english_words.sv -----
// Reads an unsigned 32-bit amount aloud as English word codes, most significant
// first, with last set on the final word; zero gives the single word ZERO. Each
// amount passes through the binary to decimal converter (one decimal digit a
// cycle, found by comparing against multiples of a billion), a walk of five word
// slots for each of the four thousand-groups, a flush of the held final word and
// the output register. The walk and the flush pause while the output is stalled.
// One word is held back so its last flag is known before it goes out. A new amount
// is taken once the previous one has handed its final word to the output register.
// Depends on n2w_pkg, n2w_if, n2w_ctrl and n2w_datapath.
module number_to_english_words import n2w_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  n2w_in_if.sink    in_i,
  n2w_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  n2w_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  n2w_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .amount_i    (in_i.amount),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.word),
    .out_last_o  (out_o.last)
  );

  a_zero_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.word == W_ZERO |-> out_o.last)
    else $error("ZERO word without last");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input ready right after an accepted amount");

  a_no_probe_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !cmd.probe && !cmd.flush)
    else $error("word pushed into a stalled output");

endmodule

// ----- rtl/n2w_ctrl.sv -----
// Sequencer for the number-to-words reader: conversion digit count, group and slot walk.
// Depends on n2w_pkg; drives the datapath through cmd_t, reads status_t.
module n2w_ctrl import n2w_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e              state_q, state_d;
  logic [ConvCntW-1:0] cnt_q, cnt_d;
  logic [GroupW-1:0]   group_q, group_d;
  slot_e               slot_q, slot_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_q == ConvCntW'(DigitCnt - 1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free && slot_q == SLOT_MAG && group_q == '0) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    group_d = group_q;
    slot_d  = slot_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d   = '0;
        group_d = '1;
        slot_d  = SLOT_HDIG;
      end
      ST_CONV: begin
        cnt_d = cnt_q + ConvCntW'(1);
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          if (slot_q == SLOT_MAG) begin
            slot_d  = SLOT_HDIG;
            group_d = group_q - GroupW'(1);
          end else begin
            slot_d = slot_e'(slot_q + 3'd1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.group   = group_q;
    cmd_o.slot    = slot_q;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV:  cmd_o.convert = 1'b1;
      ST_EMIT:  cmd_o.probe   = status_i.out_free;
      ST_FLUSH: cmd_o.flush   = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      group_q <= '1;
      slot_q  <= SLOT_HDIG;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      group_q <= group_d;
      slot_q  <= slot_d;
    end
  end

endmodule

// ----- rtl/n2w_datapath.sv -----
// Datapath: compare-and-subtract binary to decimal, group word lookup, pending and output words.
// Depends on n2w_pkg; steered by cmd_t from n2w_ctrl.
module n2w_datapath import n2w_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [AmountW-1:0] amount_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WordW-1:0]   out_word_o,
  output logic               out_last_o
);

  logic [RemW-1:0]    rem_q, rem_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [WordW-1:0]   pend_q, pend_d;
  logic               pend_vld_q, pend_vld_d;
  logic               out_vld_q, out_vld_d;
  logic [WordW-1:0]   out_word_q, out_word_d;
  logic               out_last_q, out_last_d;

  logic [RemW:0]      trial;
  logic [RemW-1:0]    left;
  logic [DigitW-1:0]  dig;

  logic [DigitW-1:0]  hund, tens, ones;
  logic [WordW-1:0]   rest;
  logic [WordW-1:0]   word;
  logic               hit;

  // take the largest multiple of a billion that fits, then scale the rest by ten
  always_comb begin
    dig   = '0;
    left  = rem_q;
    trial = '0;
    for (int k = 1; k < DigitCnt; k++) begin
      trial = {1'b0, rem_q} - (RemW+1)'(64'(k) * Giga);
      if (!trial[RemW]) begin
        dig  = DigitW'(k);
        left = trial[RemW-1:0];
      end
    end
  end

  always_comb begin
    case (cmd_i.group)
      2'd1: begin
        hund = bcd_q[23:20];
        tens = bcd_q[19:16];
        ones = bcd_q[15:12];
      end
      2'd2: begin
        hund = bcd_q[35:32];
        tens = bcd_q[31:28];
        ones = bcd_q[27:24];
      end
      2'd3: begin
        hund = '0;
        tens = '0;
        ones = bcd_q[39:36];
      end
      default: begin
        hund = bcd_q[11:8];
        tens = bcd_q[7:4];
        ones = bcd_q[3:0];
      end
    endcase
  end

  always_comb begin
    rest = WordW'(ones);
    if (tens == DigitW'(1)) rest = W_TEN + WordW'(ones);
    hit  = 1'b0;
    word = W_ZERO;
    case (cmd_i.slot)
      SLOT_HDIG: begin
        hit  = hund != '0;
        word = WordW'(hund);
      end
      SLOT_HUND: begin
        hit  = hund != '0;
        word = W_HUNDRED;
      end
      SLOT_TENS: begin
        hit  = tens inside {[4'd2:4'd15]};
        word = W_TENS_OFF + WordW'(tens);
      end
      SLOT_ONES: begin
        hit  = rest != '0;
        word = rest;
      end
      SLOT_MAG: begin
        hit  = (cmd_i.group != '0) && ((hund | tens | ones) != '0);
        word = mag_word(cmd_i.group);
      end
      default: ;
    endcase
  end

  always_comb begin
    rem_d      = rem_q;
    bcd_d      = bcd_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_word_d = out_word_q;
    out_last_d = out_last_q;
    if (cmd_i.load) begin
      rem_d      = {{(RemW-AmountW){1'b0}}, amount_i};
      bcd_d      = '0;
      pend_vld_d = 1'b0;
    end
    if (cmd_i.convert) begin
      bcd_d = {bcd_q[BcdW-DigitW-1:0], dig};
      rem_d = {left[RemW-4:0], 3'b000} + {left[RemW-2:0], 1'b0};
    end
    if (cmd_i.probe && hit) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_word_d = pend_q;
        out_last_d = 1'b0;
      end
      pend_d     = word;
      pend_vld_d = 1'b1;
    end
    if (cmd_i.flush) begin
      out_vld_d  = 1'b1;
      out_word_d = pend_vld_q ? pend_q : W_ZERO;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    bcd_q      <= bcd_d;
    pend_q     <= pend_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign status_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o       = out_vld_q;
  assign out_word_o        = out_word_q;
  assign out_last_o        = out_last_q;

endmodule

// ----- bench/n2w_word_checker.sv -----
// Watches the amount and word channels of the number-to-words reader and
// predicts every word, comparing each one taken from the output in order.
// Depends on n2w_pkg for widths and word codes.
module n2w_word_checker import n2w_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               amt_valid_i,
  input  logic               amt_ready_i,
  input  logic [AmountW-1:0] amount_i,
  input  logic               word_valid_i,
  input  logic               word_ready_i,
  input  logic [WordW-1:0]   word_i,
  input  logic               last_i,
  output int unsigned        fail_cnt_o,
  output int unsigned        pending_o,
  output int unsigned        amounts_o,
  output int unsigned        words_o
);

  localparam logic [WordW-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [WordW-1:0] WORD_MILLION  = 5'd30;
  localparam logic [WordW-1:0] WORD_BILLION  = 5'd31;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } spoken_t;

  spoken_t     words_due[$];
  int unsigned fails;
  int unsigned amounts_seen;
  int unsigned words_seen;

  function automatic void read_aloud(input logic [AmountW-1:0] amt);
    spoken_t            said[$];
    logic [AmountW-1:0] div;
    logic [AmountW-1:0] grp;
    logic [AmountW-1:0] rest;
    int                 g;
    if (amt == '0) begin
      said.push_back('{word: W_ZERO, last: 1'b0});
    end else begin
      for (g = 3; g >= 0; g--) begin
        case (g)
          3: div = 32'd1000000000;
          2: div = 32'd1000000;
          1: div = 32'd1000;
          default: div = 32'd1;
        endcase
        grp = (amt / div) % 32'd1000;
        if (grp != '0) begin
          if (grp / 32'd100 != '0) begin
            said.push_back('{word: WordW'(grp / 32'd100), last: 1'b0});
            said.push_back('{word: W_HUNDRED, last: 1'b0});
          end
          rest = grp % 32'd100;
          if (rest >= 32'd20) begin
            said.push_back('{word: W_TENS_OFF + WordW'(rest / 32'd10), last: 1'b0});
            rest = rest % 32'd10;
          end
          if (rest != '0) begin
            said.push_back('{word: WordW'(rest), last: 1'b0});
          end
          case (g)
            3: said.push_back('{word: WORD_BILLION, last: 1'b0});
            2: said.push_back('{word: WORD_MILLION, last: 1'b0});
            1: said.push_back('{word: WORD_THOUSAND, last: 1'b0});
            default: ;
          endcase
        end
      end
    end
    said[said.size()-1].last = 1'b1;
    foreach (said[i]) words_due.push_back(said[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spoken_t due;
    if (!rst_ni) begin
      words_due.delete();
      fails        = 0;
      amounts_seen = 0;
      words_seen   = 0;
      fail_cnt_o   <= 0;
      pending_o    <= 0;
      amounts_o    <= 0;
      words_o      <= 0;
    end else begin
      if (amt_valid_i && amt_ready_i) begin
        read_aloud(amount_i);
        amounts_seen++;
      end
      if (word_valid_i && word_ready_i) begin
        words_seen++;
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got word %0d last %0b",
                   $time, word_i, last_i);
          fails++;
        end else begin
          due = words_due.pop_front();
          if (due.word !== word_i || due.last !== last_i) begin
            $display("%0t: word mismatch, expected word %0d last %0b, got word %0d last %0b",
                     $time, due.word, due.last, word_i, last_i);
            fails++;
          end
        end
      end
      fail_cnt_o <= fails;
      pending_o  <= words_due.size();
      amounts_o  <= amounts_seen;
      words_o    <= words_seen;
    end
  end

endmodule

// ----- bench/number_to_english_words_tb.sv -----
// Top of the number-to-words bench: clock, reset, amount stimulus and word sink
// with idle and stall mixes. Depends on n2w_pkg, n2w_if, the block and n2w_word_checker.
module number_to_english_words_tb;
  import n2w_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 88;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_pct;
  int unsigned stall_pct;
  logic        hold_req;
  int unsigned cycles;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned amounts;
  int unsigned words;

  n2w_in_if  amt_c ();
  n2w_out_if word_c ();

  number_to_english_words dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (amt_c),
    .out_o  (word_c)
  );

  n2w_word_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .amt_valid_i  (amt_c.valid),
    .amt_ready_i  (amt_c.ready),
    .amount_i     (amt_c.amount),
    .word_valid_i (word_c.valid),
    .word_ready_i (word_c.ready),
    .word_i       (word_c.word),
    .last_i       (word_c.last),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .amounts_o    (amounts),
    .words_o      (words)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    word_c.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        word_c.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      word_c.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_amount(input logic [AmountW-1:0] amt);
    while ($urandom_range(99) < send_pct) begin
      amt_c.valid <= 1'b0;
      @(posedge clk_i);
    end
    amt_c.valid  <= 1'b1;
    amt_c.amount <= amt;
    @(posedge clk_i);
    while (!amt_c.ready) @(posedge clk_i);
  endtask

  function automatic logic [AmountW-1:0] pick_amount();
    longint unsigned sum;
    int unsigned     grp;
    int unsigned     kind;
    int              g;
    kind = $urandom_range(9);
    if (kind < 2) return $urandom();
    if (kind == 2) return AmountW'($urandom_range(999));
    if (kind == 3) return $urandom() >> $urandom_range(31);
    sum = 0;
    for (g = 3; g >= 0; g--) begin
      case ($urandom_range(7))
        0, 1: grp = 0;
        2: grp = $urandom_range(19);
        3: grp = 100 * $urandom_range(9);
        default: grp = $urandom_range(999);
      endcase
      if (g == 3) grp = grp % 5;
      sum = sum * 1000 + grp;
    end
    if (sum > 64'hFFFF_FFFF) sum -= 64'd1000000000;
    return AmountW'(sum);
  endfunction

  initial begin
    logic [AmountW-1:0] directed[$];
    int                 phase;
    int                 n;
    cycles       = 0;
    send_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    rst_ni       = 1'b0;
    amt_c.valid  = 1'b0;
    amt_c.amount = '0;
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd19, 32'd20, 32'd21, 32'd99,
                 32'd100, 32'd101, 32'd110, 32'd119, 32'd999, 32'd1000, 32'd1001,
                 32'd1000000, 32'd1000000000, 32'd2000000000, 32'd1000001000,
                 32'd12012012, 32'd999999999, 32'h8000_0000, 32'd3777777777,
                 32'hFFFF_FFFF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_amount(directed[i]);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 54; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 54; end
        default: begin send_pct = 7; stall_pct = 7; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 30) hold_req = 1'b1;
        send_amount(pick_amount());
      end
    end

    amt_c.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Read %0d amounts aloud as %0d words: boundary values, mixed zero groups,",
             amounts, words);
    $display("idle and stall mixes on both sides and one long output hold-off.");
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
